### design/lfu_pkg.sv
// Package with shared types, status codes and opcodes for the LFU replacement table.
`timescale 1ns / 1ps
package lfu_pkg;
    localparam int DefaultSlots = 32;
    localparam logic [31:0] CapacityReset = 32'd4096;

    localparam logic [1:0] OP_ACCESS  = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_EVICT   = 2'd2;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_HIT       = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_EVICTED   = 3'd5;
    localparam logic [2:0] ST_NONE      = 3'd6;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key_tag;
        logic [15:0] entry_bytes;
        logic [31:0] size_offset;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] out_key;
        logic [15:0] out_bytes;
        logic [31:0] out_count;
        logic        last;
    } rsp_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture request, reset scan
        logic scan_step;  // examine one slot
        logic commit;     // apply access or remove, build result
        logic evict;      // remove the chosen victim, build result
        logic none;       // build nothing-evicted result
        logic rescan;     // restart the scan for the next victim
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_done;
        logic need_evict;
        logic have_victim;
        logic [1:0] op;
    } sts_t;
endpackage

### design/lfu_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface lfu_req_if;
    logic valid;
    logic ready;
    lfu_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lfu_rsp_if;
    logic valid;
    logic ready;
    lfu_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/lfu_datapath.sv
// Slot table, serial scan unit and result register of the LFU table.
`timescale 1ns / 1ps
module lfu_datapath #(
    parameter int SLOTS = lfu_pkg::DefaultSlots
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lfu_pkg::cmd_t  cmd,
    input  lfu_pkg::req_t  req,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_data,
    output lfu_pkg::sts_t  sts,
    output lfu_pkg::rsp_t  rsp
);
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0] valid_reg;
    logic [63:0] key_mem [SLOTS];
    logic [31:0] count_mem [SLOTS];
    logic [15:0] bytes_mem [SLOTS];
    logic [31:0] total_reg;
    logic [31:0] cap_reg;
    lfu_pkg::req_t req_reg;
    lfu_pkg::rsp_t rsp_reg;

    logic [CW-1:0] idx_reg;
    logic          hit_reg, free_reg, vic_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg, vic_idx_reg;
    logic [31:0]   vic_cnt_reg;

    logic          rd_en_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [63:0]   rd_key_reg;
    logic [31:0]   rd_cnt_reg;

    logic [IW-1:0] cur;
    logic          at_end;
    logic          rd_slot_valid;
    logic [32:0]   need_sum;

    assign cur           = idx_reg[IW-1:0];
    assign at_end        = (idx_reg == CW'(SLOTS));
    assign rd_slot_valid = valid_reg[rd_idx_reg];
    assign need_sum      = {1'b0, total_reg} + {1'b0, req_reg.size_offset};

    // The scan ends once every slot has been read and the last read compared.
    assign sts.scan_done   = at_end && !rd_en_reg;
    assign sts.need_evict  = (total_reg != 32'd0) && (need_sum > {1'b0, cap_reg});
    assign sts.have_victim = vic_reg;
    assign sts.op          = req_reg.op;
    assign rsp             = rsp_reg;

    function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [15:0] b);
        sat_sub = (a >= {16'd0, b}) ? a - {16'd0, b} : 32'd0;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            total_reg <= '0;
            cap_reg   <= lfu_pkg::CapacityReset;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            vic_reg   <= 1'b0;
            rd_en_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_data;
            if (cmd.load || cmd.rescan)
            begin
                idx_reg   <= '0;
                hit_reg   <= 1'b0;
                free_reg  <= 1'b0;
                vic_reg   <= 1'b0;
                rd_en_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (!at_end)
                    idx_reg <= idx_reg + CW'(1);
                rd_en_reg <= !at_end;
                if (rd_en_reg)
                begin
                    if (rd_slot_valid && rd_key_reg == req_reg.key_tag && !hit_reg)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                    end
                    if (!rd_slot_valid && !free_reg)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= rd_idx_reg;
                    end
                    // Strict less-than keeps the lowest slot among equal counts.
                    if (rd_slot_valid && (!vic_reg || rd_cnt_reg < vic_cnt_reg))
                    begin
                        vic_reg     <= 1'b1;
                        vic_idx_reg <= rd_idx_reg;
                        vic_cnt_reg <= rd_cnt_reg;
                    end
                end
            end
            if (cmd.commit)
            begin
                if (req_reg.op == lfu_pkg::OP_ACCESS)
                begin
                    if (!hit_reg && free_reg)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        total_reg <= total_reg + {16'd0, req_reg.entry_bytes};
                    end
                end
                else if (hit_reg)
                begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                    total_reg <= sat_sub(total_reg, bytes_mem[hit_idx_reg]);
                end
            end
            if (cmd.evict)
            begin
                valid_reg[vic_idx_reg] <= 1'b0;
                total_reg <= sat_sub(total_reg, bytes_mem[vic_idx_reg]);
            end
        end
    end

    // Payload storage, scan read port and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.scan_step && !at_end)
        begin
            rd_idx_reg <= cur;
            rd_key_reg <= key_mem[cur];
            rd_cnt_reg <= count_mem[cur];
        end
        if (cmd.commit && req_reg.op == lfu_pkg::OP_ACCESS)
        begin
            if (hit_reg)
            begin
                if (count_mem[hit_idx_reg] != 32'hFFFF_FFFF)
                    count_mem[hit_idx_reg] <= count_mem[hit_idx_reg] + 32'd1;
            end
            else if (free_reg)
            begin
                key_mem[free_idx_reg]   <= req_reg.key_tag;
                count_mem[free_idx_reg] <= 32'd1;
                bytes_mem[free_idx_reg] <= req_reg.entry_bytes;
            end
        end
        if (cmd.commit)
        begin
            rsp_reg.last    <= 1'b1;
            rsp_reg.out_key <= req_reg.key_tag;
            if (req_reg.op == lfu_pkg::OP_ACCESS)
            begin
                if (hit_reg)
                begin
                    rsp_reg.status    <= lfu_pkg::ST_HIT;
                    rsp_reg.out_bytes <= bytes_mem[hit_idx_reg];
                    rsp_reg.out_count <= (count_mem[hit_idx_reg] != 32'hFFFF_FFFF) ?
                                         count_mem[hit_idx_reg] + 32'd1 : 32'hFFFF_FFFF;
                end
                else if (free_reg)
                begin
                    rsp_reg.status    <= lfu_pkg::ST_INSERTED;
                    rsp_reg.out_bytes <= req_reg.entry_bytes;
                    rsp_reg.out_count <= 32'd1;
                end
                else
                begin
                    rsp_reg.status    <= lfu_pkg::ST_FULL;
                    rsp_reg.out_bytes <= '0;
                    rsp_reg.out_count <= '0;
                end
            end
            else if (hit_reg)
            begin
                rsp_reg.status    <= lfu_pkg::ST_REMOVED;
                rsp_reg.out_bytes <= bytes_mem[hit_idx_reg];
                rsp_reg.out_count <= count_mem[hit_idx_reg];
            end
            else
            begin
                rsp_reg.status    <= lfu_pkg::ST_NOT_FOUND;
                rsp_reg.out_bytes <= '0;
                rsp_reg.out_count <= '0;
            end
        end
        if (cmd.evict)
        begin
            rsp_reg.status    <= lfu_pkg::ST_EVICTED;
            rsp_reg.out_key   <= key_mem[vic_idx_reg];
            rsp_reg.out_bytes <= bytes_mem[vic_idx_reg];
            rsp_reg.out_count <= vic_cnt_reg;
            // The last victim is known once the total after removal is checked.
            rsp_reg.last <= (sat_sub(total_reg, bytes_mem[vic_idx_reg]) == 32'd0) ||
                ({1'b0, sat_sub(total_reg, bytes_mem[vic_idx_reg])} +
                 {1'b0, req_reg.size_offset} <= {1'b0, cap_reg}) ||
                ($countones(valid_reg) == 1);
        end
        if (cmd.none)
        begin
            rsp_reg.status    <= lfu_pkg::ST_NONE;
            rsp_reg.out_key   <= '0;
            rsp_reg.out_bytes <= '0;
            rsp_reg.out_count <= '0;
            rsp_reg.last      <= 1'b1;
        end
    end
endmodule

### design/lfu_ctrl.sv
// Sequencer for the LFU table: load, scan, commit or evict, hand off the result.
`timescale 1ns / 1ps
module lfu_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  logic          rsp_last,
    input  lfu_pkg::sts_t sts,
    output lfu_pkg::cmd_t cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_OUT   = 3'd3;

    logic [2:0] state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                    state_next = S_DEC;
                else
                    cmd.scan_step = 1'b1;
            end
            S_DEC:
            begin
                priority case (sts.op)
                    lfu_pkg::OP_ACCESS, lfu_pkg::OP_REMOVE:
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_OUT;
                    end
                    lfu_pkg::OP_EVICT:
                    begin
                        if (sts.need_evict && sts.have_victim)
                            cmd.evict = 1'b1;
                        else
                            cmd.none = 1'b1;
                        state_next = S_OUT;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (rsp_last)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.rescan = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

### design/lfu_replacement_table.sv
// Top level of the LFU replacement table.
//   channel   dir  handshake      payload
//   req       in   valid/ready    op, key_tag, entry_bytes, size_offset
//   rsp       out  valid/ready    status, out_key, out_bytes, out_count, last
//   cfg       in   cfg_we         cfg_data (capacity_bytes)
// The first result of an item is presented after a full scan of the slot table; each
// further victim of an evict needs a new scan, and the next item is accepted in the
// cycle after the last result is taken. The scan reads one slot per cycle through a
// registered read port.
// Reset clears all valid bits, the total and the state machine; capacity returns to 4096.
// A stalled result holds the block in its output state until it is taken.
`timescale 1ns / 1ps
module lfu_replacement_table #(
    parameter int SLOTS = lfu_pkg::DefaultSlots
) (
    input  logic        clk,
    input  logic        rst_n,
    lfu_req_if.sink     req,
    lfu_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data
);
    lfu_pkg::cmd_t cmd;
    lfu_pkg::sts_t sts;
    lfu_pkg::rsp_t rsp_data;

    assign rsp.data = rsp_data;

    lfu_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .rsp_last(rsp_data.last), .sts(sts), .cmd(cmd)
    );

    lfu_datapath #(.SLOTS(SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .req(req.data),
        .cfg_we(cfg_we), .cfg_data(cfg_data), .sts(sts), .rsp(rsp_data)
    );

    a_excl_io: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid)) else $error("input and output active together");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan_step, cmd.commit, cmd.evict, cmd.none, cmd.rescan}))
        else $error("conflicting datapath commands");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.evict || cmd.none) |=> rsp.valid)
        else $error("result not presented");
endmodule

### verif/testbench.sv
// Self-checking testbench for the LFU replacement table with a scoreboard class.
`timescale 1ns / 1ps
module testbench;
    localparam int SLOTS = 32;
    localparam int KEY_POOL = 48;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 3 * (SLOTS + 3);

    class lfu_scoreboard;
        bit            used [SLOTS];
        logic [63:0]   tag_of [SLOTS];
        logic [31:0]   hits_of [SLOTS];
        logic [15:0]   size_of [SLOTS];
        logic [31:0]   total;
        logic [31:0]   capacity;
        lfu_pkg::rsp_t expected_q [$];
        int            mismatches;

        function new();
            foreach (used[i]) used[i] = 0;
            total = 0;
            capacity = lfu_pkg::CapacityReset;
            mismatches = 0;
        endfunction

        function int lookup(logic [63:0] key);
            for (int i = 0; i < SLOTS; i++)
                if (used[i] && tag_of[i] == key)
                    return i;
            return -1;
        endfunction

        function void push_result(logic [2:0] st, logic [63:0] key, logic [15:0] bytes,
                                  logic [31:0] count, logic last);
            lfu_pkg::rsp_t r;
            r.status = st;
            r.out_key = key;
            r.out_bytes = bytes;
            r.out_count = count;
            r.last = last;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void note_request(lfu_pkg::req_t r);
            int idx;
            int victim;
            int n;
            idx = -1;
            n = 0;
            case (r.op)
                lfu_pkg::OP_ACCESS:
                begin
                    idx = lookup(r.key_tag);
                    if (idx >= 0)
                    begin
                        if (hits_of[idx] != 32'hFFFF_FFFF)
                            hits_of[idx]++;
                        push_result(lfu_pkg::ST_HIT, r.key_tag, size_of[idx], hits_of[idx],
                                    1'b1);
                    end
                    else
                    begin
                        for (int i = 0; i < SLOTS && idx < 0; i++)
                            if (!used[i])
                                idx = i;
                        if (idx < 0)
                            push_result(lfu_pkg::ST_FULL, r.key_tag, 16'd0, 32'd0, 1'b1);
                        else
                        begin
                            used[idx] = 1;
                            tag_of[idx] = r.key_tag;
                            hits_of[idx] = 32'd1;
                            size_of[idx] = r.entry_bytes;
                            total = total + r.entry_bytes;
                            push_result(lfu_pkg::ST_INSERTED, r.key_tag, r.entry_bytes,
                                        32'd1, 1'b1);
                        end
                    end
                end
                lfu_pkg::OP_REMOVE:
                begin
                    idx = lookup(r.key_tag);
                    if (idx < 0)
                        push_result(lfu_pkg::ST_NOT_FOUND, r.key_tag, 16'd0, 32'd0, 1'b1);
                    else
                    begin
                        used[idx] = 0;
                        total = (total >= size_of[idx]) ? total - size_of[idx] : 32'd0;
                        push_result(lfu_pkg::ST_REMOVED, r.key_tag, size_of[idx],
                                    hits_of[idx], 1'b1);
                    end
                end
                lfu_pkg::OP_EVICT:
                begin
                    while (n < SLOTS && total != 0 &&
                           ({32'd0, total} + {32'd0, r.size_offset}) > {32'd0, capacity})
                    begin
                        victim = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (used[i] && (victim < 0 || hits_of[i] < hits_of[victim]))
                                victim = i;
                        if (victim < 0)
                            break;
                        used[victim] = 0;
                        total = (total >= size_of[victim]) ? total - size_of[victim] : 32'd0;
                        push_result(lfu_pkg::ST_EVICTED, tag_of[victim], size_of[victim],
                                    hits_of[victim], 1'b0);
                        n++;
                    end
                    if (n == 0)
                        push_result(lfu_pkg::ST_NONE, 64'd0, 16'd0, 32'd0, 1'b1);
                    else
                        expected_q[$].last = 1'b1;
                end
                default:
                begin
                    // The unused opcode is dropped by the block without a result.
                end
            endcase
        endfunction

        function void check_result(lfu_pkg::rsp_t got);
            lfu_pkg::rsp_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d key %h bytes %0d count %0d last %0d",
                             got.status, got.out_key, got.out_bytes, got.out_count, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.out_key !== want.out_key ||
                got.out_bytes !== want.out_bytes || got.out_count !== want.out_count ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %0d/%h/%0d/%0d/%0d got %0d/%h/%0d/%0d/%0d",
                             want.status, want.out_key, want.out_bytes, want.out_count,
                             want.last, got.status, got.out_key, got.out_bytes,
                             got.out_count, got.last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;
    lfu_req_if   req_ch ();
    lfu_rsp_if   rsp_ch ();

    lfu_replacement_table #(.SLOTS(SLOTS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    lfu_scoreboard table_model = new();
    logic [63:0]   key_pool [KEY_POOL];
    int            idle_cycles = 0;
    int            stall_mode = 0;
    int            stall_phase = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver: switches between random stall patterns, one of which never stalls.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            table_model.check_result(rsp_ch.data);
        stall_phase <= stall_phase + 1;
        if (stall_phase % 64 == 63)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
            2: rsp_ch.ready <= ((stall_phase % 11) < 3);
            default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(lfu_pkg::req_t r);
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        table_model.note_request(r);
    endtask

    task automatic pause_sender(int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (table_model.expected_q.size() != 0)
            @(posedge clk);
        // An ignored opcode may still be in flight with nothing expected.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        table_model.capacity = value;
    endtask

    function automatic lfu_pkg::req_t build_item(logic [1:0] op, logic [63:0] key,
                                                 logic [15:0] bytes, logic [31:0] offset);
        lfu_pkg::req_t r;
        r.op = op;
        r.key_tag = key;
        r.entry_bytes = bytes;
        r.size_offset = offset;
        return r;
    endfunction

    function automatic lfu_pkg::req_t random_item();
        int          pick;
        logic [1:0]  op;
        logic [15:0] bytes;
        logic [31:0] offset;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            op = lfu_pkg::OP_ACCESS;
        else if (pick < 75)
            op = lfu_pkg::OP_REMOVE;
        else if (pick < 94)
            op = lfu_pkg::OP_EVICT;
        else
            op = lfu_pkg::OP_IGNORED;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            bytes = 16'hFFFF;
        else if (pick == 1)
            bytes = 16'd0;
        else if (pick < 4)
            bytes = 16'($urandom);
        else
            bytes = 16'($urandom_range(0, 400));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            offset = 32'd0;
        else if (pick == 1)
            offset = $urandom;
        else
            offset = $urandom_range(0, 6000);
        return build_item(op, key_pool[$urandom_range(0, KEY_POOL - 1)], bytes, offset);
    endfunction

    initial
    begin
        logic [31:0] caps [5];
        int          sent;
        int          burst;
        rst_n = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = 64'd0;
        key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme keys and sizes, hit, not found, nothing evicted,
        // the ignored opcode, then an evict that empties the table.
        send_item(build_item(lfu_pkg::OP_ACCESS, key_pool[0], 16'd0, 32'd0));
        send_item(build_item(lfu_pkg::OP_ACCESS, key_pool[1], 16'hFFFF, 32'hFFFF_FFFF));
        send_item(build_item(lfu_pkg::OP_ACCESS, key_pool[1], 16'd5, 32'd0));
        send_item(build_item(lfu_pkg::OP_ACCESS, key_pool[2], 16'd100, 32'd0));
        send_item(build_item(lfu_pkg::OP_REMOVE, key_pool[3], 16'd0, 32'd0));
        send_item(build_item(lfu_pkg::OP_REMOVE, key_pool[2], 16'd0, 32'd0));
        send_item(build_item(lfu_pkg::OP_EVICT, 64'd0, 16'd0, 32'd0));
        send_item(build_item(lfu_pkg::OP_IGNORED, key_pool[4], 16'd7, 32'd9));
        send_item(build_item(lfu_pkg::OP_ACCESS, key_pool[4], 16'd10, 32'd0));
        send_item(build_item(lfu_pkg::OP_EVICT, 64'd0, 16'd0, 32'd4000));
        send_item(build_item(lfu_pkg::OP_EVICT, 64'd0, 16'd0, 32'hFFFF_FFFF));
        send_item(build_item(lfu_pkg::OP_EVICT, 64'd0, 16'd0, 32'hFFFF_FFFF));
        send_item(build_item(lfu_pkg::OP_REMOVE, key_pool[1], 16'd0, 32'd0));

        caps[0] = 32'd0;
        caps[1] = 32'hFFFF_FFFF;
        caps[2] = 32'd2000;
        caps[3] = $urandom;
        caps[4] = lfu_pkg::CapacityReset;
        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            set_capacity(caps[ph]);
            sent = 0;
            while (sent < 70)
            begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && sent < 70; b++)
                begin
                    send_item(random_item());
                    sent++;
                end
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 20));
            end
        end

        drain();
        if (table_model.mismatches == 0 && table_model.expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

### lfu_replacement_table.f
design/lfu_pkg.sv
design/lfu_if.sv
design/lfu_datapath.sv
design/lfu_ctrl.sv
design/lfu_replacement_table.sv
verif/testbench.sv
